>>> rtl/cc20_pkg.sv
// Shared types, constants and round functions for the ChaCha20 byte cipher.
// Depends on nothing; every rtl module refers to it by scoped names.
package cc20_pkg;

	localparam int WORD_W      = 32;
	localparam int BLOCK_WORDS = 16;
	localparam int BLOCK_BYTES = 64;
	localparam int POS_W       = $clog2(BLOCK_BYTES);
	localparam int KEY_WORDS   = 8;
	localparam int NONCE_WORDS = 3;
	localparam int ROUND_STEPS = 40;  // 20 rounds, two half quarter-rounds each
	localparam int STEP_W      = $clog2(ROUND_STEPS);
	localparam int QUEUE_DEPTH = 4;
	localparam int REG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 64;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [BLOCK_WORDS-1:0][WORD_W-1:0] block_t;
	typedef logic [POS_W-1:0] pos_t;

	localparam logic [3:0][WORD_W-1:0] SIGMA = {
		32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
	};

	typedef enum logic [REG_IDX_W-1:0] {
		REG_KEY_LO    = 3'd0,
		REG_KEY_Q2    = 3'd1,
		REG_KEY_Q3    = 3'd2,
		REG_KEY_HI    = 3'd3,
		REG_NONCE_LO  = 3'd4,
		REG_NONCE_HI  = 3'd5,
		REG_INIT_CTR  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_of_message;
	} text_item_t;

	typedef struct packed {
		logic [7:0] cipher_byte;
		logic       last_out;
	} cipher_item_t;

	// Queue entry: the item plus its place in the keystream.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		pos_t       pos;
		logic       start;
	} q_item_t;

	typedef struct packed {
		logic [KEY_WORDS-1:0][WORD_W-1:0]   key;
		logic [NONCE_WORDS-1:0][WORD_W-1:0] nonce;
		word_t                              init_ctr;
	} cfg_t;

	typedef struct packed {
		logic  start;
		logic  abort;
		word_t ctr;
	} kg_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} kg_stat_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} quad_t;

	function automatic word_t rotl(word_t v, int n);
		return (v << n) | (v >> (WORD_W - n));
	endfunction

	// First or second half of a quarter round.
	function automatic quad_t qr_half(quad_t q, logic second);
		quad_t r;
		r   = q;
		r.a = q.a + q.b;
		r.d = second ? rotl(q.d ^ r.a, 8) : rotl(q.d ^ r.a, 16);
		r.c = q.c + r.d;
		r.b = second ? rotl(q.b ^ r.c, 7) : rotl(q.b ^ r.c, 12);
		return r;
	endfunction

	function automatic block_t init_state(cfg_t c, word_t ctr);
		block_t s;
		for (int i = 0; i < 4; i++) begin
			s[i] = SIGMA[i];
		end
		for (int i = 0; i < KEY_WORDS; i++) begin
			s[4+i] = c.key[i];
		end
		s[12] = ctr;
		for (int i = 0; i < NONCE_WORDS; i++) begin
			s[13+i] = c.nonce[i];
		end
		return s;
	endfunction

endpackage

>>> rtl/cc20_front.sv
// Front end: takes input items, tags each with its byte position and message start.
// Depends on cc20_pkg.
module cc20_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 text_valid,
	output logic                 text_ready,
	input  cc20_pkg::text_item_t text_item,
	output logic                 push,
	output cc20_pkg::q_item_t    push_item,
	input  logic                 full
);

	cc20_pkg::pos_t pos_q;
	logic           start_q;

	assign text_ready = !full;
	assign push       = text_valid && text_ready;

	assign push_item = '{
		data_byte: text_item.data_byte,
		last:      text_item.last_of_message,
		pos:       pos_q,
		start:     start_q
	};

	// Position wraps at the block size; a last byte restarts the message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			start_q <= 1'b1;
		end else if (push) begin
			if (text_item.last_of_message) begin
				pos_q   <= '0;
				start_q <= 1'b1;
			end else begin
				pos_q   <= pos_q + cc20_pkg::POS_W'(1);
				start_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/cc20_queue.sv
// Short first-word-fall-through queue between front and back end.
// Depends on cc20_pkg.
module cc20_queue #(
	parameter int DEPTH = cc20_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cc20_pkg::q_item_t push_item,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output cc20_pkg::q_item_t head_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cc20_pkg::q_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/cc20_keygen.sv
// Iterative ChaCha20 block function: one half quarter-round on all four columns
// or diagonals per cycle, then the final feed-forward add. Depends on cc20_pkg.
module cc20_keygen (
	input  logic               clk,
	input  logic               arst_n,
	input  cc20_pkg::cfg_t     cfg,
	input  cc20_pkg::kg_ctrl_t ctrl,
	output cc20_pkg::kg_stat_t stat,
	output cc20_pkg::block_t   block
);

	typedef enum logic [1:0] {
		KG_IDLE,
		KG_ROUND,
		KG_FINAL
	} kg_state_t;

	kg_state_t                     state_q;
	logic [cc20_pkg::STEP_W-1:0]   step_q;
	cc20_pkg::word_t               ctr_q;
	cc20_pkg::block_t              x_q;
	cc20_pkg::block_t              x_nxt;
	cc20_pkg::block_t              init_blk;
	logic                          second;
	logic                          diag;

	assign second = step_q[0];
	assign diag   = step_q[1];

	always_comb begin
		cc20_pkg::quad_t qi;
		cc20_pkg::quad_t qo;
		x_nxt = x_q;
		for (int i = 0; i < 4; i++) begin
			if (diag) begin
				qi = '{x_q[i], x_q[4+((i+1)%4)], x_q[8+((i+2)%4)], x_q[12+((i+3)%4)]};
				qo = cc20_pkg::qr_half(qi, second);
				x_nxt[i]            = qo.a;
				x_nxt[4+((i+1)%4)]  = qo.b;
				x_nxt[8+((i+2)%4)]  = qo.c;
				x_nxt[12+((i+3)%4)] = qo.d;
			end else begin
				qi = '{x_q[i], x_q[4+i], x_q[8+i], x_q[12+i]};
				qo = cc20_pkg::qr_half(qi, second);
				x_nxt[i]    = qo.a;
				x_nxt[4+i]  = qo.b;
				x_nxt[8+i]  = qo.c;
				x_nxt[12+i] = qo.d;
			end
		end
	end

	// Feed-forward: rebuild the input state from the held counter.
	assign init_blk = cc20_pkg::init_state(cfg, ctr_q);

	always_comb begin
		for (int i = 0; i < cc20_pkg::BLOCK_WORDS; i++) begin
			block[i] = x_q[i] + init_blk[i];
		end
	end

	assign stat.busy = (state_q != KG_IDLE);
	assign stat.done = (state_q == KG_FINAL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KG_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				KG_IDLE: begin
					if (ctrl.start) begin
						step_q  <= '0;
						state_q <= KG_ROUND;
					end
				end
				KG_ROUND: begin
					if (ctrl.abort) begin
						state_q <= KG_IDLE;
					end else begin
						step_q <= step_q + cc20_pkg::STEP_W'(1);
						if (step_q == cc20_pkg::STEP_W'(cc20_pkg::ROUND_STEPS - 1)) begin
							state_q <= KG_FINAL;
						end
					end
				end
				KG_FINAL: begin
					state_q <= KG_IDLE;
				end
				default: begin
					state_q <= KG_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == KG_IDLE && ctrl.start) begin
			x_q   <= cc20_pkg::init_state(cfg, ctrl.ctr);
			ctr_q <= ctrl.ctr;
		end else if (state_q == KG_ROUND) begin
			x_q <= x_nxt;
		end
	end

endmodule

>>> rtl/cc20_back.sv
// Back end: holds the current, first-of-message and next keystream blocks,
// schedules the block generator, XORs queue items and registers the result.
// Depends on cc20_pkg.
module cc20_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cc20_pkg::cfg_t         cfg,
	input  logic                   cfg_write,
	input  logic                   head_valid,
	input  cc20_pkg::q_item_t      head_item,
	output logic                   pop,
	output logic                   cipher_valid,
	input  logic                   cipher_ready,
	output cc20_pkg::cipher_item_t cipher_item,
	output cc20_pkg::kg_ctrl_t     kg_ctrl,
	input  cc20_pkg::kg_stat_t     kg_stat,
	input  cc20_pkg::block_t       kg_block
);

	cc20_pkg::block_t       cur_q;
	cc20_pkg::block_t       fb_q;
	cc20_pkg::block_t       nb_q;
	cc20_pkg::word_t        cur_ctr_q;
	cc20_pkg::word_t        nb_ctr_q;
	cc20_pkg::word_t        job_ctr_q;
	logic                   fb_valid_q;
	logic                   nb_valid_q;
	logic                   job_fb_q;
	logic                   out_valid_q;
	cc20_pkg::cipher_item_t out_item_q;

	cc20_pkg::word_t        want_ctr;
	logic                   nb_hit;
	logic                   new_blk;
	logic                   ks_ok;
	cc20_pkg::word_t        src_word;
	logic [7:0]             ks_byte;

	assign want_ctr = cur_ctr_q + 32'd1;
	assign nb_hit   = nb_valid_q && (nb_ctr_q == want_ctr);
	assign new_blk  = (head_item.pos == '0);
	assign ks_ok    = !new_blk || (head_item.start ? fb_valid_q : nb_hit);
	assign pop      = head_valid && ks_ok && (!out_valid_q || cipher_ready);

	always_comb begin
		if (new_blk) begin
			src_word = head_item.start ? fb_q[0] : nb_q[0];
		end else begin
			src_word = cur_q[head_item.pos[cc20_pkg::POS_W-1:2]];
		end
		case (head_item.pos[1:0])
			2'd0:    ks_byte = src_word[7:0];
			2'd1:    ks_byte = src_word[15:8];
			2'd2:    ks_byte = src_word[23:16];
			default: ks_byte = src_word[31:24];
		endcase
	end

	// First-of-message block has priority; then keep the block after the
	// current one ready. Drop a job whose target moved or whose inputs changed.
	assign kg_ctrl.start = !kg_stat.busy && !cfg_write && (!fb_valid_q || !nb_hit);
	assign kg_ctrl.ctr   = !fb_valid_q ? cfg.init_ctr : want_ctr;
	assign kg_ctrl.abort = kg_stat.busy &&
		(cfg_write || (!job_fb_q && (job_ctr_q != want_ctr)));

	assign cipher_valid = out_valid_q;
	assign cipher_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_valid_q  <= 1'b0;
			nb_valid_q  <= 1'b0;
			job_fb_q    <= 1'b0;
			job_ctr_q   <= '0;
			nb_ctr_q    <= '0;
			cur_ctr_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (kg_ctrl.start) begin
				job_fb_q  <= !fb_valid_q;
				job_ctr_q <= kg_ctrl.ctr;
			end
			// New key material: cached blocks are stale, the held one stays.
			if (cfg_write) begin
				fb_valid_q <= 1'b0;
				nb_valid_q <= 1'b0;
			end else if (kg_stat.done) begin
				if (job_fb_q) begin
					fb_valid_q <= 1'b1;
				end else begin
					nb_valid_q <= 1'b1;
					nb_ctr_q   <= job_ctr_q;
				end
			end
			if (pop && new_blk) begin
				cur_ctr_q <= head_item.start ? cfg.init_ctr : want_ctr;
			end
			out_valid_q <= pop || (out_valid_q && !cipher_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (kg_stat.done) begin
			if (job_fb_q) begin
				fb_q <= kg_block;
			end else begin
				nb_q <= kg_block;
			end
		end
		if (pop) begin
			out_item_q <= '{
				cipher_byte: head_item.data_byte ^ ks_byte,
				last_out:    head_item.last
			};
			if (new_blk) begin
				cur_q <= head_item.start ? fb_q : nb_q;
			end
		end
	end

endmodule

>>> rtl/chacha20_stream_cipher.sv
// ChaCha20 byte stream cipher, top level: configuration registers, front end,
// queue, block generator and back end. Depends on cc20_pkg and all rtl modules.
//
// One byte goes in and one byte comes out per cycle, sustained, while the output
// is ready and keystream is at hand; each byte passes the queue and the output
// register. Keystream comes from a single iterative block generator that builds
// each 64-byte block by a load, 40 half quarter-round steps and the feed-forward
// add; it computes the next block of a message while the bytes of the current
// one stream through, and the back end also keeps the first block of a message
// (initial counter) cached, so a new message starts without a gap. After reset,
// and after any register write, both cached blocks are rebuilt: the first byte
// waits for its block, and so does a message that reaches its second block
// before that block is rebuilt. A block held when a key or nonce is rewritten
// mid-message finishes with the old values; the next block uses the new ones,
// and a new initial counter takes effect with the next message. Registers are
// written through wr_en/wr_index/wr_data; the user must write them only while
// no item is in flight, unchecked by the block; index 7 is ignored. The queue
// between front and back decouples the input side from a stalled output side.
module chacha20_stream_cipher #(
	parameter int QUEUE_DEPTH = cc20_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             wr_en,
	input  logic [cc20_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [cc20_pkg::CFG_DATA_W-1:0]  wr_data,
	input  logic                             text_valid,
	output logic                             text_ready,
	input  cc20_pkg::text_item_t             text_item,
	output logic                             cipher_valid,
	input  logic                             cipher_ready,
	output cc20_pkg::cipher_item_t           cipher_item
);

	cc20_pkg::cfg_t     cfg_q;
	logic               cfg_hit;
	logic               cfg_write;
	cc20_pkg::reg_idx_t wr_reg;

	logic               push;
	cc20_pkg::q_item_t  push_item;
	logic               full;
	logic               pop;
	logic               head_valid;
	cc20_pkg::q_item_t  head_item;

	cc20_pkg::kg_ctrl_t kg_ctrl;
	cc20_pkg::kg_stat_t kg_stat;
	cc20_pkg::block_t   kg_block;

	assign wr_reg = cc20_pkg::reg_idx_t'(wr_index);

	// Decode: only listed register indexes count as a write.
	always_comb begin
		unique case (wr_reg) inside
			cc20_pkg::REG_KEY_LO, cc20_pkg::REG_KEY_Q2, cc20_pkg::REG_KEY_Q3,
			cc20_pkg::REG_KEY_HI, cc20_pkg::REG_NONCE_LO, cc20_pkg::REG_NONCE_HI,
			cc20_pkg::REG_INIT_CTR: begin
				cfg_hit = 1'b1;
			end
			default: begin
				cfg_hit = 1'b0;
			end
		endcase
	end

	assign cfg_write = wr_en && cfg_hit;

	// Register file: key and NONCE_LO registers carry two words, low word first; the others take only the low word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_reg)
				cc20_pkg::REG_KEY_LO: begin
					cfg_q.key[0] <= wr_data[31:0];
					cfg_q.key[1] <= wr_data[63:32];
				end
				cc20_pkg::REG_KEY_Q2: begin
					cfg_q.key[2] <= wr_data[31:0];
					cfg_q.key[3] <= wr_data[63:32];
				end
				cc20_pkg::REG_KEY_Q3: begin
					cfg_q.key[4] <= wr_data[31:0];
					cfg_q.key[5] <= wr_data[63:32];
				end
				cc20_pkg::REG_KEY_HI: begin
					cfg_q.key[6] <= wr_data[31:0];
					cfg_q.key[7] <= wr_data[63:32];
				end
				cc20_pkg::REG_NONCE_LO: begin
					cfg_q.nonce[0] <= wr_data[31:0];
					cfg_q.nonce[1] <= wr_data[63:32];
				end
				cc20_pkg::REG_NONCE_HI: begin
					cfg_q.nonce[2] <= wr_data[31:0];
				end
				cc20_pkg::REG_INIT_CTR: begin
					cfg_q.init_ctr <= wr_data[31:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	cc20_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_item  (text_item),
		.push       (push),
		.push_item  (push_item),
		.full       (full)
	);

	cc20_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	cc20_keygen u_keygen (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.ctrl   (kg_ctrl),
		.stat   (kg_stat),
		.block  (kg_block)
	);

	cc20_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cfg_write    (cfg_write),
		.head_valid   (head_valid),
		.head_item    (head_item),
		.pop          (pop),
		.cipher_valid (cipher_valid),
		.cipher_ready (cipher_ready),
		.cipher_item  (cipher_item),
		.kg_ctrl      (kg_ctrl),
		.kg_stat      (kg_stat),
		.kg_block     (kg_block)
	);

	// A message always opens on a block boundary.
	a_start_on_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && head_item.start) |-> (head_item.pos == '0))
		else $error("message start item not at block position zero");

	// The generator takes every job it is handed.
	a_job_taken: assert property (@(posedge clk) disable iff (!arst_n)
		kg_ctrl.start |=> kg_stat.busy)
		else $error("block generator ignored a start");

	// A finished block has run the full round schedule.
	a_full_schedule: assert property (@(posedge clk) disable iff (!arst_n)
		kg_stat.done |-> $past(kg_stat.busy, cc20_pkg::ROUND_STEPS))
		else $error("block finished before all rounds ran");

endmodule
